// ===== rtl/plob_pkg.sv =====
// Shared types and constants for the price-level order book.
`default_nettype none
package plob_pkg;
  localparam int PRICE_W  = 32;
  localparam int AMOUNT_W = 31;
  localparam int STAMP_W  = 64;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;
  localparam logic SIDE_ASK    = 1'b0;
  localparam logic SIDE_BID    = 1'b1;

  // Classified command passed from front to back.
  typedef struct packed {
    logic                is_report;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [AMOUNT_W-1:0] amount;
    logic [STAMP_W-1:0]  stamp;
  } cmd_t;

  // One report word.
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [PRICE_W-1:0]  bid_price;
    logic [AMOUNT_W-1:0] bid_amount;
    logic                bid_ok;
    logic [PRICE_W-1:0]  ask_price;
    logic [AMOUNT_W-1:0] ask_amount;
    logic                ask_ok;
    logic                dropped;
  } rpt_t;
endpackage
`default_nettype wire

// ===== rtl/plob_front.sv =====
// Front end: input word decode and a two-entry command queue.
`default_nettype none
module plob_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_user,
  input  wire logic [127:0]    in_data,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output plob_pkg::cmd_t       cmd
);
  plob_pkg::cmd_t q_r [2];
  plob_pkg::cmd_t dec;
  logic           wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  // Field decode: kind on the user bit; side, price, amount, timestamp from the low bits up
  always_comb begin
    dec.is_report = (in_user == plob_pkg::KIND_REPORT);
    dec.side      = in_data[0];
    dec.price     = in_data[32:1];
    dec.amount    = in_data[63:33];
    dec.stamp     = in_data[127:64];
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/plob_side.sv =====
// One side's level table with a slot scan that finds the hit, free slot and best level.
`default_nettype none
module plob_side #(
  parameter int LEVELS = 256,
  parameter bit WANT_HIGH = 1'b0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [plob_pkg::PRICE_W-1:0]  key,
  input  wire logic [plob_pkg::AMOUNT_W-1:0] amount,
  input  wire logic                          do_update,
  output logic                               done,
  output logic                               overflow,
  output logic [plob_pkg::PRICE_W-1:0]       best_price,
  output logic [plob_pkg::AMOUNT_W-1:0]      best_amount,
  output logic                               best_ok
);
  localparam int IW = $clog2(LEVELS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_LAST = 4'b0100, S_APPLY = 4'b1000
  } st_t;

  logic [plob_pkg::PRICE_W-1:0]  prc_mem [LEVELS];
  logic [plob_pkg::AMOUNT_W-1:0] amt_mem [LEVELS];
  logic [LEVELS-1:0]             used_r;

  st_t     st_r, st_nxt;
  logic [IW-1:0] idx_r, rd_idx_r;
  logic          rd_used_r;
  logic [plob_pkg::PRICE_W-1:0]  rd_prc_r;
  logic [plob_pkg::AMOUNT_W-1:0] rd_amt_r;
  logic          hit_ok_r, free_ok_r;
  logic [IW-1:0] hit_r, free_r;
  logic          rd_live, better;

  assign rd_live = (st_r == S_SCAN) || (st_r == S_LAST);
  assign better  = WANT_HIGH ? (rd_prc_r > best_price) : (rd_prc_r < best_price);
  assign done    = (st_r == S_APPLY);

  // Scan sequencer: one slot read per cycle, each slot compared in the cycle after its read
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (start) st_nxt = S_SCAN;
      S_SCAN:  if (idx_r == IW'(LEVELS - 1)) st_nxt = S_LAST;
      S_LAST:  st_nxt = S_APPLY;
      S_APPLY: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      used_r   <= '0;
      idx_r    <= '0;
      overflow <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      overflow <= 1'b0;
      if (st_r == S_IDLE) idx_r <= '0;
      else if (st_r == S_SCAN) idx_r <= idx_r + 1'b1;
      if (st_r == S_APPLY && do_update) begin
        if (amount == '0) begin
          if (hit_ok_r) used_r[hit_r] <= 1'b0;
        end else if (!hit_ok_r) begin
          if (free_ok_r) used_r[free_r] <= 1'b1;
          else overflow <= 1'b1;
        end
      end
    end
  end

  // Memory read port and write port
  always_ff @(posedge clk) begin
    rd_prc_r  <= prc_mem[idx_r];
    rd_amt_r  <= amt_mem[idx_r];
    rd_used_r <= used_r[idx_r];
    rd_idx_r  <= idx_r;
    if (st_r == S_APPLY && do_update && amount != '0) begin
      if (hit_ok_r) begin
        amt_mem[hit_r] <= amount;
      end else if (free_ok_r) begin
        prc_mem[free_r] <= key;
        amt_mem[free_r] <= amount;
      end
    end
  end

  // Running hit, free slot and best level
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE) begin
      hit_ok_r    <= 1'b0;
      free_ok_r   <= 1'b0;
      best_ok     <= 1'b0;
      best_price  <= '0;
      best_amount <= '0;
      hit_r       <= '0;
      free_r      <= '0;
    end else if (rd_live && (st_r == S_LAST || idx_r != '0)) begin
      if (rd_used_r) begin
        if (!hit_ok_r && rd_prc_r == key) begin
          hit_ok_r <= 1'b1;
          hit_r    <= rd_idx_r;
        end
        if (!best_ok || better) begin
          best_ok     <= 1'b1;
          best_price  <= rd_prc_r;
          best_amount <= rd_amt_r;
        end
      end else if (!free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= rd_idx_r;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/plob_back.sv =====
// Back end: runs commands on both tables and holds the report in an output register.
`default_nettype none
module plob_back #(
  parameter int LEVELS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire plob_pkg::cmd_t cmd,
  output logic                rpt_valid,
  input  wire logic           rpt_ready,
  output plob_pkg::rpt_t      rpt
);
  logic busy_r, ovf_r, ovf_nxt;
  logic ask_done, bid_done, ask_ovf, bid_ovf, start;
  logic [plob_pkg::PRICE_W-1:0]  ap, bp;
  logic [plob_pkg::AMOUNT_W-1:0] aa, ba;
  logic aok, bok;

  // A report only starts its sweep once the report register is free
  assign cmd_ready = busy_r && ask_done && bid_done;
  assign start     = cmd_valid && !busy_r && !(cmd.is_report && rpt_valid);

  plob_side #(.LEVELS(LEVELS), .WANT_HIGH(1'b0)) u_ask (
    .clk, .rst_n, .start, .key(cmd.price), .amount(cmd.amount),
    .do_update(!cmd.is_report && cmd.side == plob_pkg::SIDE_ASK),
    .done(ask_done), .overflow(ask_ovf),
    .best_price(ap), .best_amount(aa), .best_ok(aok)
  );
  plob_side #(.LEVELS(LEVELS), .WANT_HIGH(1'b1)) u_bid (
    .clk, .rst_n, .start, .key(cmd.price), .amount(cmd.amount),
    .do_update(!cmd.is_report && cmd.side == plob_pkg::SIDE_BID),
    .done(bid_done), .overflow(bid_ovf),
    .best_price(bp), .best_amount(ba), .best_ok(bok)
  );

  // Drop flag: set by a failed insert, cleared when a report's sweep completes
  always_comb begin
    ovf_nxt = ovf_r || ask_ovf || bid_ovf;
    if (cmd_ready && cmd_valid && cmd.is_report) ovf_nxt = ask_ovf || bid_ovf;
  end

  // Both tables scan in lock step; a report is held back from its sweep
  // while the report register is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ovf_r     <= 1'b0;
      rpt_valid <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
      if (start) busy_r <= 1'b1;
      else if (cmd_ready) busy_r <= 1'b0;
      if (rpt_valid && rpt_ready) rpt_valid <= 1'b0;
      if (cmd_ready && cmd.is_report) rpt_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd.is_report) begin
      rpt.stamp      <= cmd.stamp;
      rpt.bid_price  <= bp;
      rpt.bid_amount <= ba;
      rpt.bid_ok     <= bok;
      rpt.ask_price  <= ap;
      rpt.ask_amount <= aa;
      rpt.ask_ok     <= aok;
      rpt.dropped    <= ovf_r;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/price_level_order_book.sv =====
// Top level of the price-level order book.
//
//  channel | dir | word contents
//  in_     | in  | tuser: kind; tdata: side, price, amount, timestamp
//  out_    | out | tdata: time, best bid, best ask, present flags, drop flag
//
// Each item runs one sweep: each table is swept one slot per cycle
// through its single memory read port, then an apply state writes back.
// Reset clears the used bits at once; no clearing pass.
// A two-word queue decouples input from the sweep; a report waits before
// its sweep while the output register still holds an untaken word.
`default_nettype none
module price_level_order_book #(
  parameter int LEVELS = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // kind[0]
  input  wire logic         in_tuser,
  // side[0], price[32:1], amount[63:33], timestamp[127:64]
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // time_out[63:0], best_bid_price[95:64], best_bid_amount[126:96],
  // bid_present[127], best_ask_price[159:128], best_ask_amount[190:160],
  // ask_present[191], dropped_insert[192], zeros
  output logic [199:0]      out_tdata
);
  plob_pkg::cmd_t cmd;
  plob_pkg::rpt_t rpt;
  logic cmd_valid, cmd_ready;

  plob_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_user(in_tuser), .in_data(in_tdata), .cmd_valid, .cmd_ready, .cmd
  );

  plob_back #(.LEVELS(LEVELS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .rpt_valid(out_tvalid), .rpt_ready(out_tready), .rpt
  );

  assign out_tdata = {7'd0, rpt.dropped, rpt.ask_ok, rpt.ask_amount, rpt.ask_price,
                      rpt.bid_ok, rpt.bid_amount, rpt.bid_price, rpt.stamp};

  // Output word holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  // A queue that refuses input is never empty
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> cmd_valid)
    else $error("queue full but empty");
endmodule
`default_nettype wire

// ===== sim/price_level_order_book_tb.sv =====
// Self-checking testbench for the price-level order book: table-driven and random updates/reports.
`timescale 1ns / 1ps
module price_level_order_book_tb;

  localparam int LEVELS   = 256;
  localparam int PRICE_W  = plob_pkg::PRICE_W;
  localparam int AMOUNT_W = plob_pkg::AMOUNT_W;
  localparam int STAMP_W  = plob_pkg::STAMP_W;

  // Report word fields as the checker sees them
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [PRICE_W-1:0]  bid_price;
    logic [AMOUNT_W-1:0] bid_amount;
    logic                bid_ok;
    logic [PRICE_W-1:0]  ask_price;
    logic [AMOUNT_W-1:0] ask_amount;
    logic                ask_ok;
    logic                dropped;
  } top_of_book_t;

  // Directed stimulus row; has_exp marks a hand-written expected report
  typedef struct {
    logic                kind;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [AMOUNT_W-1:0] amount;
    logic [STAMP_W-1:0]  stamp;
    bit                  has_exp;
    top_of_book_t        exp;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic         in_tuser;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;

  // Book shadow: index 0 = asks, 1 = bids
  logic [PRICE_W-1:0]  book_price  [2][LEVELS];
  logic [AMOUNT_W-1:0] book_amount [2][LEVELS];
  bit                  book_used   [2][LEVELS];
  bit                  drop_seen;

  top_of_book_t pending_reports[$];
  int  errors;
  int  words_sent;
  int  reports_seen;
  int  drops_seen;
  int  idle_phase;
  logic [PRICE_W-1:0] price_pool[2][16];

  price_level_order_book #(.LEVELS(LEVELS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Set, modify, remove or drop one level on a side
  function automatic void apply_level_update(logic side, logic [PRICE_W-1:0] price,
                                             logic [AMOUNT_W-1:0] amount);
    int hit;
    int free_slot;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < LEVELS; i++) begin
      if (book_used[side][i]) begin
        if (hit < 0 && book_price[side][i] == price) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (amount == '0) begin
      if (hit >= 0) book_used[side][hit] = 0;
    end else if (hit >= 0) begin
      book_amount[side][hit] = amount;
    end else if (free_slot >= 0) begin
      book_price[side][free_slot]  = price;
      book_amount[side][free_slot] = amount;
      book_used[side][free_slot]   = 1;
    end else begin
      drop_seen = 1;
    end
  endfunction

  // Best bid (highest) and best ask (lowest), then clear the drop flag
  function automatic top_of_book_t best_levels(logic [STAMP_W-1:0] stamp);
    top_of_book_t r;
    r = '{stamp, '0, '0, 1'b0, '0, '0, 1'b0, drop_seen};
    for (int i = 0; i < LEVELS; i++) begin
      if (book_used[plob_pkg::SIDE_BID][i] &&
          (!r.bid_ok || book_price[plob_pkg::SIDE_BID][i] > r.bid_price)) begin
        r.bid_price  = book_price[plob_pkg::SIDE_BID][i];
        r.bid_amount = book_amount[plob_pkg::SIDE_BID][i];
        r.bid_ok     = 1'b1;
      end
      if (book_used[plob_pkg::SIDE_ASK][i] &&
          (!r.ask_ok || book_price[plob_pkg::SIDE_ASK][i] < r.ask_price)) begin
        r.ask_price  = book_price[plob_pkg::SIDE_ASK][i];
        r.ask_amount = book_amount[plob_pkg::SIDE_ASK][i];
        r.ask_ok     = 1'b1;
      end
    end
    drop_seen = 0;
    return r;
  endfunction

  // Sender gap per idling phase: none, sender, receiver, both
  function automatic int sender_gap();
    if ((idle_phase == 1 || idle_phase == 3) &&
        $urandom_range(99, 0) < ((idle_phase == 1) ? 61 : 13))
      return $urandom_range(4, 1);
    return 0;
  endfunction

  // Drive one word and wait for it to be taken; predict on acceptance
  task automatic send_word(logic kind, logic side, logic [PRICE_W-1:0] price,
                           logic [AMOUNT_W-1:0] amount, logic [STAMP_W-1:0] stamp,
                           bit has_exp, top_of_book_t exp);
    int gap;
    top_of_book_t r;
    idle_phase = (words_sent / 100) % 4;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {stamp, amount, price, side};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (kind == plob_pkg::KIND_UPDATE) begin
      apply_level_update(side, price, amount);
    end else begin
      r = best_levels(stamp);
      if (r.dropped) drops_seen++;
      pending_reports.push_back(has_exp ? exp : r);
    end
  endtask

  task automatic send_update(logic side, logic [PRICE_W-1:0] price,
                             logic [AMOUNT_W-1:0] amount);
    top_of_book_t none;
    none = '{'0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0};
    send_word(plob_pkg::KIND_UPDATE, side, price, amount, {$urandom, $urandom}, 0, none);
  endtask

  task automatic send_report();
    top_of_book_t none;
    none = '{'0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0};
    send_word(plob_pkg::KIND_REPORT, 1'($urandom_range(1, 0)), $urandom,
              AMOUNT_W'($urandom), {$urandom, $urandom}, 0, none);
  endtask

  // Fill one side past capacity, report twice, then empty it again with periodic reports
  task automatic overflow_side(logic side);
    logic [PRICE_W-1:0] base;
    base = $urandom;
    for (int i = 0; i < LEVELS + 4; i++)
      send_update(side, base + PRICE_W'(i * 3),
                  AMOUNT_W'($urandom_range(32'h7fff_ffff, 1)));
    send_report();
    send_report();
    for (int i = 0; i < LEVELS + 4; i++) begin
      send_update(side, base + PRICE_W'(i * 3), '0);
      if (i % 64 == 0) send_report();
    end
  endtask

  // Receiver stalls per idling phase
  always @(posedge clk) begin
    if (idle_phase == 2)
      out_tready <= ($urandom_range(99, 0) >= 61);
    else if (idle_phase == 3)
      out_tready <= ($urandom_range(99, 0) >= 13);
    else
      out_tready <= 1'b1;
  end

  // Result checker
  always @(posedge clk) begin
    top_of_book_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.stamp      = out_tdata[63:0];
      got.bid_price  = out_tdata[95:64];
      got.bid_amount = out_tdata[126:96];
      got.bid_ok     = out_tdata[127];
      got.ask_price  = out_tdata[159:128];
      got.ask_amount = out_tdata[190:160];
      got.ask_ok     = out_tdata[191];
      got.dropped    = out_tdata[192];
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report word, actual %p", $time, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.stamp !== want.stamp)
          $display("%0t: time_out expected %h actual %h", $time, want.stamp, got.stamp);
        if (got.bid_price !== want.bid_price)
          $display("%0t: best_bid_price expected %h actual %h", $time,
                   want.bid_price, got.bid_price);
        if (got.bid_amount !== want.bid_amount)
          $display("%0t: best_bid_amount expected %h actual %h", $time,
                   want.bid_amount, got.bid_amount);
        if (got.bid_ok !== want.bid_ok)
          $display("%0t: bid_present expected %b actual %b", $time, want.bid_ok, got.bid_ok);
        if (got.ask_price !== want.ask_price)
          $display("%0t: best_ask_price expected %h actual %h", $time,
                   want.ask_price, got.ask_price);
        if (got.ask_amount !== want.ask_amount)
          $display("%0t: best_ask_amount expected %h actual %h", $time,
                   want.ask_amount, got.ask_amount);
        if (got.ask_ok !== want.ask_ok)
          $display("%0t: ask_present expected %b actual %b", $time, want.ask_ok, got.ask_ok);
        if (got.dropped !== want.dropped)
          $display("%0t: dropped_insert expected %b actual %b", $time,
                   want.dropped, got.dropped);
        if (got !== want) errors++;
      end
    end
  end

  // Run cap
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus
  initial begin
    row_t rows[$];
    top_of_book_t empty_book;
    logic side;
    int op;
    empty_book = '{'0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0};
    in_tvalid     = 1'b0;
    in_tuser      = 1'b0;
    in_tdata      = '0;
    rst_n         = 1'b0;
    errors        = 0;
    words_sent    = 0;
    reports_seen  = 0;
    drops_seen    = 0;
    idle_phase    = 0;
    drop_seen     = 0;
    foreach (book_used[s, i]) begin
      book_used[s][i]   = 0;
      book_price[s][i]  = '0;
      book_amount[s][i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: empty book, extremes, modify, remove, absent remove
    rows.push_back('{plob_pkg::KIND_REPORT, plob_pkg::SIDE_ASK, '0, '0, 64'h0, 1,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_REPORT, plob_pkg::SIDE_BID, '1, '1, '1, 1,
                     '{'1, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0}});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, '1, '1, '0, 0, empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, '0, '1, '1, 0, empty_book});
    rows.push_back('{plob_pkg::KIND_REPORT, plob_pkg::SIDE_ASK, '0, '0,
                     64'h0123_4567_89ab_cdef, 1,
                     '{64'h0123_4567_89ab_cdef, '0, '1, 1'b1, '1, '1, 1'b1, 1'b0}});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, 32'd100, 31'd5, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, 32'd100, 31'd9, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, 32'd200, 31'd3, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, 32'd150, 31'd1, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_REPORT, plob_pkg::SIDE_BID, 32'h5555_aaaa, 31'h2aaa_5555,
                     64'hfedc_ba98_7654_3210, 0, empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, 32'd555, '0, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, 32'd100, '0, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_ASK, '1, '0, '0, 0, empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, '0, '0, '0, 0, empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, 32'd200, '0, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_UPDATE, plob_pkg::SIDE_BID, 32'd150, '0, '0, 0,
                     empty_book});
    rows.push_back('{plob_pkg::KIND_REPORT, plob_pkg::SIDE_ASK, '0, '0, 64'd42, 1,
                     '{64'd42, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0}});
    foreach (rows[i])
      send_word(rows[i].kind, rows[i].side, rows[i].price, rows[i].amount,
                rows[i].stamp, rows[i].has_exp, rows[i].exp);

    // Random: pooled prices so levels get hit, modified and removed
    foreach (price_pool[s, i]) price_pool[s][i] = $urandom;
    for (int n = 0; n < 180; n++) begin
      if (n == 60) begin
        // let everything drain before carrying on
        in_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        overflow_side(plob_pkg::SIDE_BID);
      end
      if (n == 120) overflow_side(plob_pkg::SIDE_ASK);
      if (n % 40 == 39) price_pool[$urandom_range(1, 0)][$urandom_range(15, 0)] = $urandom;
      op = $urandom_range(99, 0);
      side = 1'($urandom_range(1, 0));
      if (op < 15)
        send_report();
      else if (op < 35)
        send_update(side, price_pool[side][$urandom_range(15, 0)], '0);
      else if (op < 90)
        send_update(side, price_pool[side][$urandom_range(15, 0)],
                    AMOUNT_W'($urandom_range(32'h7fff_ffff, 1)));
      else
        send_update(side, $urandom, AMOUNT_W'($urandom));
    end
    send_report();
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2 * LEVELS + 20) @(posedge clk);
    if (pending_reports.size() != 0) errors++;
    $display("Sent %0d words (two table overflows included), checked %0d reports,",
             words_sent, reports_seen);
    $display("%0d with the dropped-insert flag, under four idling patterns.", drops_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/plob_pkg.sv
rtl/plob_front.sv
rtl/plob_side.sv
rtl/plob_back.sv
rtl/price_level_order_book.sv
sim/price_level_order_book_tb.sv
